// ----- design/range_memory_type_resolver_unit_assert.svh -----
// ----------------------------------------------------------------------------
// range memory type resolver assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef RANGE_MEMORY_TYPE_RESOLVER_UNIT_ASSERT_SVH
`define RANGE_MEMORY_TYPE_RESOLVER_UNIT_ASSERT_SVH

// same-cycle implication
`define RMTR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rmtr_pkg.sv -----
// ----------------------------------------------------------------------------
// rmtr_pkg
// types and constants shared by the range memory type resolver
// ----------------------------------------------------------------------------
package rmtr_pkg;

  localparam int RMTR_MAX_RANGES_DEF = 16;

  localparam int ADDR_W  = 52;
  localparam int TYPE_W  = 8;
  localparam int IDX_W   = 4;
  localparam int COUNT_W = 5;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;
  // wide enough for any cell position up to 128 cells
  localparam int POS_W   = 7;

  localparam logic [TYPE_W-1:0] CODE_UC = 8'h00;
  localparam logic [TYPE_W-1:0] CODE_WT = 8'h04;

  // byte offset masks of a 4 KiB and a 2 MiB page
  localparam logic [ADDR_W-1:0] SMALL_MASK = 52'h0_0000_0000_0FFF;
  localparam logic [ADDR_W-1:0] BIG_MASK   = 52'h0_0000_001F_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_COUNT  = 1'b0,
    CFG_DEFAULT_TYPE = 1'b1
  } rmtr_cfg_e;

  typedef struct packed {
    logic              func;
    logic [IDX_W-1:0]  entry_index;
    logic [ADDR_W-1:0] entry_base;
    logic [ADDR_W-1:0] entry_end;
    logic [TYPE_W-1:0] entry_type;
    logic [ADDR_W-1:0] page_address;
    logic              large_page;
  } rmtr_in_t;

  typedef struct packed {
    logic [TYPE_W-1:0] memory_type;
    logic              split_needed;
  } rmtr_out_t;

  // beat travelling down the cell row; a write beat carries base, end and
  // type in page_first, page_last and kind
  typedef struct packed {
    logic              is_query;
    logic [IDX_W-1:0]  entry_index;
    logic              big;
    logic [ADDR_W-1:0] page_first;
    logic [ADDR_W-1:0] page_last;
    logic [TYPE_W-1:0] kind;
    logic              saw_wt;
    logic              done;
    logic              split;
  } rmtr_tok_t;

endpackage

// ----- design/rmtr_cell.sv -----
// ----------------------------------------------------------------------------
// rmtr_cell
// one range entry plus one pipeline slot of the resolver cell row
// ----------------------------------------------------------------------------
`include "range_memory_type_resolver_unit_assert.svh"

module rmtr_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [rmtr_pkg::COUNT_W-1:0]  range_count,
  input  logic                          in_vld,
  input  rmtr_pkg::rmtr_tok_t           in_tok,
  output logic                          out_vld,
  output rmtr_pkg::rmtr_tok_t           out_tok
);
  import rmtr_pkg::*;

  localparam logic [POS_W-1:0] POS = POS_W'(CELL_IDX);

  logic [ADDR_W-1:0] ent_base;
  logic [ADDR_W-1:0] ent_end;
  logic [TYPE_W-1:0] ent_type;

  logic      active;
  logic      holds;
  logic      touches;
  logic      wr_hit;
  rmtr_tok_t tok_next;

  assign active  = {{(POS_W-COUNT_W){1'b0}}, range_count} > POS;
  assign wr_hit  = in_vld && !in_tok.is_query &&
                   ({{(POS_W-IDX_W){1'b0}}, in_tok.entry_index} == POS);
  assign holds   = (in_tok.page_first >= ent_base) && (in_tok.page_last <= ent_end);
  assign touches = !((in_tok.page_first > ent_end) || (in_tok.page_last < ent_base));

  always_comb begin
    tok_next = in_tok;
    if (in_tok.is_query && !in_tok.done && active) begin
      if (holds) begin
        tok_next.kind = ent_type;
        if (ent_type == CODE_UC) begin
          tok_next.done   = 1'b1;
          tok_next.saw_wt = 1'b0;
        end else if (ent_type == CODE_WT) begin
          tok_next.saw_wt = 1'b1;
        end
      end else if (in_tok.big && touches) begin
        // partial overlap of a large page ends the scan
        tok_next.done   = 1'b1;
        tok_next.split  = 1'b1;
        tok_next.kind   = '0;
        tok_next.saw_wt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tok <= tok_next;
    end
  end

  // entry storage, no reset: undefined until written
  always_ff @(posedge clk) begin
    if (adv && wr_hit) begin
      ent_base <= in_tok.page_first;
      ent_end  <= in_tok.page_last;
      ent_type <= in_tok.kind;
    end
  end

  `RMTR_ASSERT_NOW(a_split_clean,
    out_vld && out_tok.is_query && out_tok.split,
    out_tok.done && (out_tok.kind == CODE_UC) && !out_tok.saw_wt,
    "split beat carries a type or wt mark")
  `RMTR_ASSERT_NOW(a_done_is_uc,
    out_vld && out_tok.is_query && out_tok.done && !out_tok.split,
    (out_tok.kind == CODE_UC) && !out_tok.saw_wt,
    "finished scan without split is not uc")
  `RMTR_ASSERT_NEXT(a_done_frozen,
    adv && in_vld && in_tok.is_query && in_tok.done,
    out_vld && (out_tok == $past(in_tok)),
    "finished beat changed inside a cell")

endmodule

// ----- design/range_memory_type_resolver_unit.sv -----
// ----------------------------------------------------------------------------
// range_memory_type_resolver_unit
// memory type lookup over a row of range cells, one entry per cell
// ----------------------------------------------------------------------------
// a query result passes the register of every cell, then the output slot
// throughput: one beat per cycle, set by the cell row advancing in lock step
// a waiting result stalls the whole row until out_ready takes it
// reset clears valid bits, range_count and default_type; entries stay undefined
// ----------------------------------------------------------------------------
`include "range_memory_type_resolver_unit_assert.svh"

module range_memory_type_resolver_unit #(
  parameter int MAX_RANGES = rmtr_pkg::RMTR_MAX_RANGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input beats
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rmtr_pkg::rmtr_in_t             in_data,
  // result beats
  output logic                           out_valid,
  input  logic                           out_ready,
  output rmtr_pkg::rmtr_out_t            out_data,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [rmtr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rmtr_pkg::CFG_W-1:0]     cfg_data
);
  import rmtr_pkg::*;

  logic [COUNT_W-1:0] range_count;
  logic [TYPE_W-1:0]  default_type;

  // the whole row moves together whenever the output slot can take a beat
  logic adv;

  logic              row_vld [MAX_RANGES+1];
  rmtr_tok_t         row_tok [MAX_RANGES+1];
  logic [ADDR_W-1:0] page_mask;
  logic [ADDR_W-1:0] page_first;

  rmtr_tok_t last_tok;
  logic      last_vld;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      range_count  <= '0;
      default_type <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANGE_COUNT:  range_count  <= cfg_data[COUNT_W-1:0];
        CFG_DEFAULT_TYPE: default_type <= cfg_data[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // beat formation: queries become an aligned [first, last] page window,
  // writes ride the same fields with base, end and type
  // ---------------------------------------------------------------------
  assign page_mask  = in_data.large_page ? BIG_MASK : SMALL_MASK;
  assign page_first = in_data.page_address & ~page_mask;

  always_comb begin
    row_vld[0]             = in_valid;
    row_tok[0].is_query    = in_data.func;
    row_tok[0].entry_index = in_data.entry_index;
    row_tok[0].big         = in_data.large_page;
    row_tok[0].saw_wt      = 1'b0;
    row_tok[0].done        = 1'b0;
    row_tok[0].split       = 1'b0;
    if (in_data.func) begin
      row_tok[0].page_first = page_first;
      // aligned window, so or-ing the mask is the inclusive end with no carry
      row_tok[0].page_last  = page_first | page_mask;
      row_tok[0].kind       = default_type;
    end else begin
      row_tok[0].page_first = in_data.entry_base;
      row_tok[0].page_last  = in_data.entry_end;
      row_tok[0].kind       = in_data.entry_type;
    end
  end

  // ---------------------------------------------------------------------
  // cell row: cell k holds range entry k and checks the beat passing it
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
    rmtr_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .adv         (adv),
      .range_count (range_count),
      .in_vld      (row_vld[k]),
      .in_tok      (row_tok[k]),
      .out_vld     (row_vld[k+1]),
      .out_tok     (row_tok[k+1])
    );
  end

  assign last_vld = row_vld[MAX_RANGES];
  assign last_tok = row_tok[MAX_RANGES];

  // ---------------------------------------------------------------------
  // output slot: only query beats make a result; a wt hit outranks the
  // last holding type, split and uc already left kind at their code
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= last_vld && last_tok.is_query;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.memory_type  <= last_tok.saw_wt ? CODE_WT : last_tok.kind;
      out_data.split_needed <= last_tok.split;
    end
  end

  `RMTR_ASSERT_NOW(a_split_type_zero,
    out_valid && out_data.split_needed,
    out_data.memory_type == CODE_UC,
    "split result with nonzero memory type")
  `RMTR_ASSERT_NOW(a_result_from_query,
    $rose(out_valid),
    $past(last_vld && last_tok.is_query),
    "result appeared without a query beat leaving the row")
  `RMTR_ASSERT_NEXT(a_result_held,
    out_valid && !out_ready,
    out_valid && $stable(out_data),
    "waiting result beat dropped or changed")

endmodule

// ----- sim/rmtr_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// rmtr_tb_pkg
// beat function codes and extra memory type codes used by the testbench
// ----------------------------------------------------------------------------
package rmtr_tb_pkg;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } rmtr_func_e;

  localparam logic [rmtr_pkg::TYPE_W-1:0] CODE_WC = 8'h01;
  localparam logic [rmtr_pkg::TYPE_W-1:0] CODE_WP = 8'h05;
  localparam logic [rmtr_pkg::TYPE_W-1:0] CODE_WB = 8'h06;

endpackage

// ----- sim/range_memory_type_resolver_unit_checker.sv -----
// ----------------------------------------------------------------------------
// range_memory_type_resolver_unit_checker
// watches the beat and config channels, keeps its own range table and
// compares every result beat with the predicted memory type and split flag
// ----------------------------------------------------------------------------
module range_memory_type_resolver_unit_checker #(
  parameter int MAX_RANGES = rmtr_pkg::RMTR_MAX_RANGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  rmtr_pkg::rmtr_in_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  rmtr_pkg::rmtr_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [rmtr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rmtr_pkg::CFG_W-1:0]     cfg_data,
  output int                             mismatch_count,
  output int                             pending_results
);
  import rmtr_pkg::*;
  import rmtr_tb_pkg::*;

  logic [ADDR_W-1:0]  lo_tbl   [MAX_RANGES];
  logic [ADDR_W-1:0]  hi_tbl   [MAX_RANGES];
  logic [TYPE_W-1:0]  kind_tbl [MAX_RANGES];
  logic [COUNT_W-1:0] range_count;
  logic [TYPE_W-1:0]  default_type;
  rmtr_out_t          type_expect_q [$];

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // scan the table in order: uc or a straddled large page ends the scan, any wt wins, else last hit
  function automatic rmtr_out_t resolve_page_type(logic [ADDR_W-1:0] addr, logic big);
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] first;
    logic [ADDR_W:0]   last;
    logic [TYPE_W-1:0] kind;
    logic              saw_wt;
    int                n;
    rmtr_out_t         res;
    span   = big ? BIG_MASK : SMALL_MASK;
    first  = addr & ~span;
    last   = {1'b0, first} + {1'b0, span};
    n      = (range_count > MAX_RANGES) ? MAX_RANGES : int'(range_count);
    kind   = default_type;
    saw_wt = 1'b0;
    res    = '0;
    for (int k = 0; k < n; k++) begin
      if (first >= lo_tbl[k] && last <= {1'b0, hi_tbl[k]}) begin
        kind = kind_tbl[k];
        if (kind == CODE_UC) begin
          res.memory_type = CODE_UC;
          return res;
        end
        if (kind == CODE_WT) saw_wt = 1'b1;
      end else if (big && !(first > hi_tbl[k] || last < {1'b0, lo_tbl[k]})) begin
        // large page straddles a range edge
        res.split_needed = 1'b1;
        return res;
      end
    end
    res.memory_type = saw_wt ? CODE_WT : kind;
    return res;
  endfunction

  always @(posedge clk) begin
    rmtr_out_t want;
    if (rst) begin
      range_count  = '0;
      default_type = '0;
      type_expect_q.delete();
    end else begin
      // results leave before a same-edge query can add to the store
      if (out_valid && out_ready) begin
        if (type_expect_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing outstanding: type %0h split %0b",
                                    out_data.memory_type, out_data.split_needed));
        end else begin
          want = type_expect_q.pop_front();
          if (out_data.memory_type !== want.memory_type)
            report_mismatch($sformatf("memory_type got %0h want %0h",
                                      out_data.memory_type, want.memory_type));
          if (out_data.split_needed !== want.split_needed)
            report_mismatch($sformatf("split_needed got %0b want %0b",
                                      out_data.split_needed, want.split_needed));
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.func == FUNC_QUERY) begin
          type_expect_q.push_back(resolve_page_type(in_data.page_address, in_data.large_page));
        end else if (in_data.entry_index < MAX_RANGES) begin
          lo_tbl[in_data.entry_index]   = in_data.entry_base;
          hi_tbl[in_data.entry_index]   = in_data.entry_end;
          kind_tbl[in_data.entry_index] = in_data.entry_type;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RANGE_COUNT:  range_count  = cfg_data[COUNT_W-1:0];
          CFG_DEFAULT_TYPE: default_type = cfg_data[TYPE_W-1:0];
          default: ;
        endcase
      end
    end
    pending_results = type_expect_q.size();
  end

endmodule

// ----- sim/range_memory_type_resolver_unit_tb.sv -----
// ----------------------------------------------------------------------------
// range_memory_type_resolver_unit_tb
// drives range writes and page queries into the resolver under random
// sender gaps and receiver stalls, across several range_count and
// default_type settings; a side checker predicts and compares every result
// ----------------------------------------------------------------------------
module range_memory_type_resolver_unit_tb;
  import rmtr_pkg::*;
  import rmtr_tb_pkg::*;

  localparam int NUM_RANGES      = RMTR_MAX_RANGES_DEF;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int NUM_PHASES      = 8;
  // quiet cycles allowed before the run is declared hung
  localparam int QUIET_LIMIT     = 2000;

  typedef enum {
    RX_ALWAYS,
    RX_COIN,
    RX_BURSTY
  } rx_mode_e;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  rmtr_in_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rmtr_out_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_RANGE_COUNT;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int                   mismatch_count;
  int                   pending_results;
  int                   quiet_cycles = 0;
  int                   stall_run    = 0;
  rx_mode_e             rx_mode      = RX_ALWAYS;

  // last range written per entry, used to aim queries at range edges
  logic [ADDR_W-1:0]    lo_hint [NUM_RANGES] = '{default: '0};
  logic [ADDR_W-1:0]    hi_hint [NUM_RANGES] = '{default: '0};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  range_memory_type_resolver_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  range_memory_type_resolver_unit_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    if (stall_run != 0) begin
      stall_run--;
      out_ready = 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready = 1'b1;
        RX_COIN:   out_ready = 1'($urandom_range(0, 1));
        default: begin
          // occasional long stall, otherwise ready
          if ($urandom_range(0, 7) == 0) begin
            stall_run = $urandom_range(1, 12);
            out_ready = 1'b0;
          end else begin
            out_ready = 1'b1;
          end
        end
      endcase
    end
  end

  // hang detector: no beat moving on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // all fields random; callers overwrite the ones that matter
  function automatic rmtr_in_t noise_beat();
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(rmtr_in_t)-1:0];
  endfunction

  // 256 MiB window where most ranges and queries live
  function automatic logic [ADDR_W-1:0] window_addr();
    return ADDR_W'($urandom_range(0, 32'h0FFF_FFFF));
  endfunction

  function automatic rmtr_in_t make_write();
    rmtr_in_t          beat;
    int unsigned       gran;
    int unsigned       len;
    int unsigned       pick;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] tmp;
    beat = noise_beat();
    case ($urandom_range(0, 2))
      0:       gran = 12;
      1:       gran = 16;
      default: gran = 21;
    endcase
    len  = $urandom_range(1, 48);
    pick = $urandom_range(0, 99);
    lo   = (window_addr() >> gran) << gran;
    hi   = lo + (ADDR_W'(len) << gran) - 1'b1;
    if (pick < 10) begin
      // inverted range
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end else if (pick < 20) begin
      lo = beat.entry_base;
      hi = beat.entry_end;
    end else if (pick < 25) begin
      // ragged end, not on a page boundary
      hi = hi + ADDR_W'($urandom_range(1, 12'hFFF));
    end else if (pick < 30) begin
      // range running up to the top of the address space
      hi = '1;
      lo = hi - (ADDR_W'(len) << gran) + 1'b1;
    end
    beat.func        = FUNC_WRITE;
    beat.entry_index = IDX_W'($urandom_range(0, NUM_RANGES - 1));
    beat.entry_base  = lo;
    beat.entry_end   = hi;
    case ($urandom_range(0, 9))
      0:       beat.entry_type = CODE_UC;
      1:       beat.entry_type = CODE_WC;
      2, 3:    beat.entry_type = CODE_WT;
      4:       beat.entry_type = CODE_WP;
      5, 6, 7: beat.entry_type = CODE_WB;
      default: beat.entry_type = TYPE_W'($urandom_range(0, 255));
    endcase
    return beat;
  endfunction

  function automatic rmtr_in_t make_query();
    rmtr_in_t          beat;
    int unsigned       pick;
    int unsigned       k;
    logic [ADDR_W-1:0] anchor;
    beat            = noise_beat();
    beat.func       = FUNC_QUERY;
    beat.large_page = 1'($urandom_range(0, 1));
    pick            = $urandom_range(0, 99);
    if (pick < 45) begin
      // near an edge of a known range, within one large page either way
      k      = $urandom_range(0, NUM_RANGES - 1);
      anchor = $urandom_range(0, 1) ? lo_hint[k] : hi_hint[k];
      beat.page_address = anchor - 52'h20_0000 + ADDR_W'($urandom_range(0, 32'h3F_FFFF));
    end else if (pick < 85) begin
      beat.page_address = window_addr();
    end else if (pick >= 95) begin
      beat.page_address = $urandom_range(0, 1) ? {ADDR_W{1'b1}} : '0;
    end
    return beat;
  endfunction

  // present one beat at the falling edge and hold it until it is taken
  task automatic send_beat(input rmtr_in_t beat);
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = beat;
    if (beat.func == FUNC_WRITE) begin
      lo_hint[beat.entry_index] = beat.entry_base;
      hi_hint[beat.entry_index] = beat.entry_end;
    end
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender(input int unsigned n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] lo,
                             input logic [ADDR_W-1:0] hi, input logic [TYPE_W-1:0] kind);
    rmtr_in_t beat;
    beat             = noise_beat();
    beat.func        = FUNC_WRITE;
    beat.entry_index = idx;
    beat.entry_base  = lo;
    beat.entry_end   = hi;
    beat.entry_type  = kind;
    send_beat(beat);
  endtask

  task automatic query_page(input logic [ADDR_W-1:0] addr, input logic big);
    rmtr_in_t beat;
    beat              = noise_beat();
    beat.func         = FUNC_QUERY;
    beat.page_address = addr;
    beat.large_page   = big;
    send_beat(beat);
  endtask

  // stop sending, let every result arrive, then let trailing write beats
  // walk off the end of the cell row
  task automatic drain_row();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_results == 0);
    repeat (NUM_RANGES + 4) @(posedge clk);
  endtask

  task automatic write_reg(input rmtr_cfg_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    logic [COUNT_W-1:0] cnt;
    logic [TYPE_W-1:0]  dflt;
    int unsigned        burst_left;
    int unsigned        gap_max;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset values: no range checked, default type zero
    query_page('0, 1'b0);

    // directed table, each entry set up for one resolution rule
    write_entry(IDX_W'(0), '0, 52'h3F_FFFF, CODE_WB);            // plain write-back span
    write_entry(IDX_W'(1), 52'h10_0000, 52'h1F_FFFF, CODE_WT);   // wt inside entry 0
    write_entry(IDX_W'(2), 52'h10_0000, 52'h10_0FFF, CODE_WB);   // later match, wt still wins
    write_entry(IDX_W'(3), 52'h500_0800, 52'h500_17FF, CODE_WC); // not page aligned
    write_entry(IDX_W'(4), 52'h800_0000, 52'h8FF_FFFF, CODE_UC); // uc ahead of wp
    write_entry(IDX_W'(5), 52'h800_0000, 52'hFFF_FFFF, CODE_WP);
    write_entry(IDX_W'(6), 52'h2000_0100, 52'h2000_00FF, CODE_WB); // inverted, still overlaps
    write_entry(IDX_W'(7), 52'hF_FFFF_FFE0_0000, '1, 8'hA5);     // top of space, odd code
    for (int k = 8; k < NUM_RANGES; k++)
      write_entry(IDX_W'(k), 52'h4000_0000 + (ADDR_W'(k) << 22),
                  52'h4000_0000 + (ADDR_W'(k) << 22) + 52'h3F_FFFF,
                  (k == 8) ? 8'hFF : CODE_WP);

    drain_row();
    write_reg(CFG_RANGE_COUNT, CFG_W'(NUM_RANGES));
    write_reg(CFG_DEFAULT_TYPE, 8'h5A);

    query_page(52'h10_0000, 1'b0);             // wt beats surrounding wb
    query_page('0, 1'b1);                      // large page cut by entry 1
    query_page(52'h20_0000, 1'b1);             // large page held whole
    query_page(52'h3ABC, 1'b0);                // unaligned address
    query_page(52'h500_1000, 1'b0);            // small page only partly covered
    query_page(52'h800_0000, 1'b0);            // uc stops the scan
    query_page(52'h900_0000, 1'b0);            // only the wp range holds it
    query_page(52'h2000_0000, 1'b1);           // inverted range forces a split
    query_page({ADDR_W{1'b1}}, 1'b1);          // highest large page

    // random phases, each with its own register setting and idling style
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_row();
      dflt = TYPE_W'($urandom_range(0, 255));
      case (p)
        0: begin
          cnt  = COUNT_W'(NUM_RANGES);
          dflt = 8'hFF;
        end
        1: begin
          cnt  = '0;
          dflt = 8'h00;
        end
        2:       cnt = '1;                     // beyond the table, clipped
        3:       cnt = COUNT_W'(1);
        4:       cnt = COUNT_W'(NUM_RANGES + 1);
        5:       cnt = COUNT_W'($urandom_range(2, NUM_RANGES - 1));
        6:       cnt = COUNT_W'(NUM_RANGES);
        default: cnt = COUNT_W'($urandom_range(0, 31));
      endcase
      write_reg(CFG_RANGE_COUNT, CFG_W'(cnt));
      write_reg(CFG_DEFAULT_TYPE, dflt);

      // first phase runs flat out on both sides
      rx_mode    = rx_mode_e'(p % 3);
      gap_max    = (p == 0) ? 0 : $urandom_range(2, 8);
      burst_left = 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (burst_left == 0) begin
          if (gap_max != 0) pause_sender($urandom_range(1, gap_max));
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        if ($urandom_range(0, 3) == 0) send_beat(make_write());
        else send_beat(make_query());
      end
    end

    // catch any stray result after the last expected one
    drain_row();
    repeat (2 * NUM_RANGES + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
